[sv/sha256_stream_hasher_top_macros.svh]
// assertion macros for the sha-256 stream hasher checker
// expects signals named clk and rst in the scope of use
`ifndef SHA256_STREAM_HASHER_TOP_MACROS_SVH
`define SHA256_STREAM_HASHER_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define SHA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define SHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, checked through reset
`define SHA_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[sv/sha_pkg.sv]
// shared types, constants and tables for the sha-256 stream hasher
// used by the schedule, round core and top level; no dependencies
`default_nettype none

package sha_pkg;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [2:0] LAST_WORD = 3'd7;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PAD   = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_FOLD  = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  typedef struct packed {
    logic       shift_byte;
    logic [7:0] byte_val;
    logic       shift_word;
  } sched_ctrl_t;

  typedef struct packed {
    logic init;
    logic load;
    logic step;
    logic fold;
  } core_ctrl_t;

  function automatic logic [31:0] h_init(input logic [2:0] idx);
    logic [31:0] val;
    case (idx)
      3'd0:    val = 32'h6a09e667;
      3'd1:    val = 32'hbb67ae85;
      3'd2:    val = 32'h3c6ef372;
      3'd3:    val = 32'ha54ff53a;
      3'd4:    val = 32'h510e527f;
      3'd5:    val = 32'h9b05688c;
      3'd6:    val = 32'h1f83d9ab;
      default: val = 32'h5be0cd19;
    endcase
    return val;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] val;
    case (idx)
      6'd0:  val = 32'h428a2f98;  6'd1:  val = 32'h71374491;
      6'd2:  val = 32'hb5c0fbcf;  6'd3:  val = 32'he9b5dba5;
      6'd4:  val = 32'h3956c25b;  6'd5:  val = 32'h59f111f1;
      6'd6:  val = 32'h923f82a4;  6'd7:  val = 32'hab1c5ed5;
      6'd8:  val = 32'hd807aa98;  6'd9:  val = 32'h12835b01;
      6'd10: val = 32'h243185be;  6'd11: val = 32'h550c7dc3;
      6'd12: val = 32'h72be5d74;  6'd13: val = 32'h80deb1fe;
      6'd14: val = 32'h9bdc06a7;  6'd15: val = 32'hc19bf174;
      6'd16: val = 32'he49b69c1;  6'd17: val = 32'hefbe4786;
      6'd18: val = 32'h0fc19dc6;  6'd19: val = 32'h240ca1cc;
      6'd20: val = 32'h2de92c6f;  6'd21: val = 32'h4a7484aa;
      6'd22: val = 32'h5cb0a9dc;  6'd23: val = 32'h76f988da;
      6'd24: val = 32'h983e5152;  6'd25: val = 32'ha831c66d;
      6'd26: val = 32'hb00327c8;  6'd27: val = 32'hbf597fc7;
      6'd28: val = 32'hc6e00bf3;  6'd29: val = 32'hd5a79147;
      6'd30: val = 32'h06ca6351;  6'd31: val = 32'h14292967;
      6'd32: val = 32'h27b70a85;  6'd33: val = 32'h2e1b2138;
      6'd34: val = 32'h4d2c6dfc;  6'd35: val = 32'h53380d13;
      6'd36: val = 32'h650a7354;  6'd37: val = 32'h766a0abb;
      6'd38: val = 32'h81c2c92e;  6'd39: val = 32'h92722c85;
      6'd40: val = 32'ha2bfe8a1;  6'd41: val = 32'ha81a664b;
      6'd42: val = 32'hc24b8b70;  6'd43: val = 32'hc76c51a3;
      6'd44: val = 32'hd192e819;  6'd45: val = 32'hd6990624;
      6'd46: val = 32'hf40e3585;  6'd47: val = 32'h106aa070;
      6'd48: val = 32'h19a4c116;  6'd49: val = 32'h1e376c08;
      6'd50: val = 32'h2748774c;  6'd51: val = 32'h34b0bcb5;
      6'd52: val = 32'h391c0cb3;  6'd53: val = 32'h4ed8aa4a;
      6'd54: val = 32'h5b9cca4f;  6'd55: val = 32'h682e6ff3;
      6'd56: val = 32'h748f82ee;  6'd57: val = 32'h78a5636f;
      6'd58: val = 32'h84c87814;  6'd59: val = 32'h8cc70208;
      6'd60: val = 32'h90befffa;  6'd61: val = 32'ha4506ceb;
      6'd62: val = 32'hbef9a3f7;
      default: val = 32'hc67178f2;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

[sv/sha_stream_if.sv]
// valid/ready channel interfaces for message items and digest items
// depends on nothing
`default_nettype none

interface sha_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

`default_nettype wire

[sv/sha256_stream_hasher_top.sv]
// sha-256 stream hasher: sequencer, length count and digest output register
// depends on sha_pkg, sha_stream_if, sha_sched and sha_core
//
// usage
//   msg channel (sha_in_if): one item per byte, action 0 absorbs data_byte,
//   action 1 finishes the message. digest channel (sha_out_if): eight items
//   per finish, digest_word in big-endian order, word_index 0..7, last_word
//   on the eighth.
//   a data byte is taken when msg.valid and msg.ready are both high; the 64th
//   byte of a block starts the compression, 64 rounds on the shared round
//   unit and then a fold, and msg.ready stays low until the fold is done.
//   finish streams the padding one byte per cycle through the block buffer
//   to close the block and then compresses it, and when more than 55 bytes
//   were pending a second block is padded and compressed. the first digest
//   word is loaded in ST_OUT after the last fold and is registered, then
//   one word a cycle while the receiver takes them.
//   the output register lets the receiver stall; the word waits and the
//   next one is loaded only when the current one is taken. after the last
//   word is loaded the hasher is back in its initial state and takes items.
//   rst (synchronous) loads the initial hash values, clears the bit count
//   and fill count and drops digest.valid.
`default_nettype none

module sha256_stream_hasher_top (
  input  logic      clk,
  input  logic      rst,
  sha_in_if.sink    msg,
  sha_out_if.source digest
);
  import sha_pkg::*;

  state_t      state;
  state_t      state_next;
  logic [5:0]  fill_count;
  logic [63:0] message_bits;
  logic [5:0]  round_idx;
  logic [2:0]  word_idx;
  logic        finishing;
  logic        len_ok;
  logic        pad_mark;

  logic        out_valid;
  logic [31:0] out_word;
  logic [2:0]  out_index;
  logic        out_last;

  logic        in_fire;
  logic        out_slot;
  logic        emit;
  logic [63:0] len_shift;
  logic [7:0]  pad_byte;
  logic [31:0] chain_word;

  sched_ctrl_t sched_ctrl;
  core_ctrl_t  core_ctrl;
  logic [31:0] w_word;

  assign msg.ready = (state == ST_IDLE);
  assign in_fire   = msg.valid && msg.ready;
  assign out_slot  = !out_valid || digest.ready;
  assign emit      = (state == ST_OUT) && out_slot;

  assign digest.valid       = out_valid;
  assign digest.digest_word = out_word;
  assign digest.word_index  = out_index;
  assign digest.last_word   = out_last;

  // length bytes go out most significant first at positions 56..63
  assign len_shift = message_bits << {fill_count[2:0], 3'b000};

  always_comb begin
    if (pad_mark) begin
      pad_byte = PAD_BYTE;
    end else if (len_ok && (fill_count >= LEN_POS)) begin
      pad_byte = len_shift[63:56];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    sched_ctrl.shift_byte = (in_fire && !msg.action) || (state == ST_PAD);
    sched_ctrl.byte_val   = (state == ST_PAD) ? pad_byte : msg.data_byte;
    sched_ctrl.shift_word = (state == ST_ROUND);
    core_ctrl.init = emit && (word_idx == LAST_WORD);
    core_ctrl.load = sched_ctrl.shift_byte && (fill_count == LAST_POS);
    core_ctrl.step = (state == ST_ROUND);
    core_ctrl.fold = (state == ST_FOLD);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (msg.action) begin
            state_next = ST_PAD;
          end else if (fill_count == LAST_POS) begin
            state_next = ST_ROUND;
          end
        end
      end
      ST_PAD: begin
        if (fill_count == LAST_POS) state_next = ST_ROUND;
      end
      ST_ROUND: begin
        if (round_idx == LAST_POS) state_next = ST_FOLD;
      end
      ST_FOLD: begin
        if (finishing && len_ok) begin
          state_next = ST_OUT;
        end else if (finishing) begin
          state_next = ST_PAD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (emit && (word_idx == LAST_WORD)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      fill_count   <= '0;
      message_bits <= '0;
      round_idx    <= '0;
      word_idx     <= '0;
      finishing    <= 1'b0;
      len_ok       <= 1'b0;
      pad_mark     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (sched_ctrl.shift_byte) fill_count <= fill_count + 6'd1;
      if (state == ST_ROUND) round_idx <= round_idx + 6'd1;
      if (state == ST_PAD) pad_mark <= 1'b0;
      if (in_fire && !msg.action) begin
        message_bits <= message_bits + 64'd8;
      end
      if (in_fire && msg.action) begin
        finishing <= 1'b1;
        len_ok    <= (fill_count < LEN_POS);
        pad_mark  <= 1'b1;
      end
      if ((state == ST_FOLD) && finishing && !len_ok) len_ok <= 1'b1;
      if (emit) begin
        out_valid <= 1'b1;
        word_idx  <= word_idx + 3'd1;
      end else if (digest.ready) begin
        out_valid <= 1'b0;
      end
      if (core_ctrl.init) begin
        message_bits <= '0;
        finishing    <= 1'b0;
        len_ok       <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word  <= chain_word;
      out_index <= word_idx;
      out_last  <= (word_idx == LAST_WORD);
    end
  end

  sha_sched u_sched (
    .clk    (clk),
    .ctrl   (sched_ctrl),
    .w_word (w_word)
  );

  sha_core u_core (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (core_ctrl),
    .round_idx  (round_idx),
    .w_word     (w_word),
    .rd_idx     (word_idx),
    .chain_word (chain_word)
  );

endmodule

`default_nettype wire

[sv/sha_sched.sv]
// block buffer and message schedule window, 16 words as one shift line
// bytes shift in during intake, words shift out one per round; uses sha_pkg
`default_nettype none

module sha_sched (
  input  logic                clk,
  input  sha_pkg::sched_ctrl_t ctrl,
  output logic [31:0]         w_word
);
  import sha_pkg::*;

  logic [15:0][31:0] win;
  logic [31:0]       w_new;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  // win[15] is the oldest word of the window
  assign w_word = win[15];
  assign w_new  = sig1(win[1]) + win[6] + sig0(win[14]) + win[15];

  always_ff @(posedge clk) begin
    if (ctrl.shift_byte) begin
      win <= {win[15][23:0], win[14:0], ctrl.byte_val};
    end else if (ctrl.shift_word) begin
      win <= {win[14:0], w_new};
    end
  end

endmodule

`default_nettype wire

[sv/sha_core.sv]
// sha-256 round unit with working variables and chaining words
// one round per step, fold adds the working set into the chain; uses sha_pkg
`default_nettype none

module sha_core (
  input  logic               clk,
  input  logic               rst,
  input  sha_pkg::core_ctrl_t ctrl,
  input  logic [5:0]         round_idx,
  input  logic [31:0]        w_word,
  input  logic [2:0]         rd_idx,
  output logic [31:0]        chain_word
);
  import sha_pkg::*;

  logic [31:0] chain [8];
  logic [31:0] v     [8];
  logic [31:0] t1;
  logic [31:0] t2;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  assign t1 = v[7] + big1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
            + round_k(round_idx) + w_word;
  assign t2 = big0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  assign chain_word = chain[rd_idx];

  always_ff @(posedge clk) begin
    if (rst || ctrl.init) begin
      for (int i = 0; i < 8; i++) chain[i] <= h_init(3'(i));
    end else if (ctrl.fold) begin
      for (int i = 0; i < 8; i++) chain[i] <= chain[i] + v[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      for (int i = 0; i < 8; i++) v[i] <= chain[i];
    end else if (ctrl.step) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

endmodule

`default_nettype wire

[sv/sha_checker.sv]
// port-level checker for the sha-256 stream hasher and its bind
// depends on sha256_stream_hasher_top_macros.svh and the top level
`default_nettype none

`include "sha256_stream_hasher_top_macros.svh"

module sha_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_action,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_word,
  input logic [2:0]  out_index,
  input logic        out_last
);

  `SHA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word) && $stable(out_index) && $stable(out_last), "stalled digest item changed")
  `SHA_ASSERT_NOW(a_last_index, out_valid, out_last == (out_index == 3'd7), "last_word does not match word_index")
  `SHA_ASSERT_NEXT(a_finish_busy, in_valid && in_ready && in_action, !in_ready, "item taken right after finish")
  `SHA_ASSERT_RST(a_reset_quiet, rst, !out_valid && in_ready, "not idle after reset")

endmodule

bind sha256_stream_hasher_top sha_checker u_sha_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (msg.valid),
  .in_ready  (msg.ready),
  .in_action (msg.action),
  .out_valid (digest.valid),
  .out_ready (digest.ready),
  .out_word  (digest.digest_word),
  .out_index (digest.word_index),
  .out_last  (digest.last_word)
);

`default_nettype wire
